>>> rtl/ssconv_pkg.sv
package ssconv_pkg;

	localparam int MAX_ROWS = 4096;

	// configuration register widths
	localparam int ROWS_W = 13;
	localparam int COLS_W = 11;
	localparam int KSIZE_W = 3;

	// item field widths
	localparam int OP_W = 2;
	localparam int CIDX_W = 6;
	localparam int COEF_W = 24;
	localparam int SAMPLE_W = 32;
	localparam int OUT_W = 32;
	localparam int OROW_W = 12;
	localparam int OCOL_W = 10;

	// arithmetic
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W = 64;
	localparam int FRAC_W = 16;

	localparam int QDEPTH = 4;

	localparam logic [OP_W-1:0] OP_COEF = 2'd0;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_KSIZE = 2'd2;

	typedef struct packed {
		logic [ROWS_W-1:0] rows;
		logic [COLS_W-1:0] cols;
		logic [KSIZE_W-1:0] ksize;
	} cfg_t;

	typedef struct packed {
		logic is_coef;
		logic [CIDX_W-1:0] coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic signed [SAMPLE_W-1:0] data;
		logic emit;
		logic [OROW_W-1:0] row;
		logic [OCOL_W-1:0] col;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic [OCOL_W-1:0] col;
		logic [OROW_W-1:0] row;
	} meta_t;

	typedef struct packed {
		meta_t meta;
		logic signed [OUT_W-1:0] filtered;
	} res_t;

	// register value 0 acts as 1, values above the limit act as the limit
	function automatic int clamp_cfg(input int v, input int hi);
		int r;
		r = v;
		if (v == 0) begin
			r = 1;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

endpackage

>>> rtl/same_size_2d_convolution.sv
// throughput: one item per cycle, sustained while the result side keeps up; the
// result queue (16 entries at the defaults) covers the multiply and adder-tree pipeline
// reset: asynchronous, active low; coefficients clear to zero, registers go to
// rows 1, cols 1, kernel 3; line buffers and window are not cleared, out-of-matrix taps
// are masked
module same_size_2d_convolution #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_COLS = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata, // coef_index, coef_value, sample, zero fill
	input logic [1:0] s_axis_tuser, // op
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata, // filtered, out_row, out_col, zero fill
	output logic m_axis_tlast
);
	import ssconv_pkg::*;

	localparam int COLW = $clog2(MAX_COLS);
	localparam int QW = $bits(cmd_t) + COLW + 2 * MAX_KERNEL;

	cfg_t cfg_q;
	logic cfg_wr, restart;
	logic q_push, q_full, q_pop, q_empty;
	cmd_t f_cmd, b_cmd;
	logic [COLW-1:0] f_col, b_col;
	logic [MAX_KERNEL-1:0] f_rmask, f_cmask, b_rmask, b_cmask;
	logic [QW-1:0] q_dout;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign restart = cfg_wr && ((paddr[3:2] == REG_ROWS) || (paddr[3:2] == REG_COLS)
		|| (paddr[3:2] == REG_KSIZE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows <= ROWS_W'(1);
			cfg_q.cols <= COLS_W'(1);
			cfg_q.ksize <= KSIZE_W'(3);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_ROWS: cfg_q.rows <= pwdata[ROWS_W-1:0];
				REG_COLS: cfg_q.cols <= pwdata[COLS_W-1:0];
				REG_KSIZE: cfg_q.ksize <= pwdata[KSIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_ROWS: prdata = 32'(cfg_q.rows);
			REG_COLS: prdata = 32'(cfg_q.cols);
			REG_KSIZE: prdata = 32'(cfg_q.ksize);
			default: prdata = '0;
		endcase
	end

	ssconv_front #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_COLS(MAX_COLS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.restart(restart),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_op(s_axis_tuser),
		.in_coef_index(s_axis_tdata[5:0]),
		.in_coef_value(s_axis_tdata[29:6]),
		.in_sample(s_axis_tdata[61:30]),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(f_cmd),
		.q_col(f_col),
		.q_rmask(f_rmask),
		.q_cmask(f_cmask)
	);

	ssconv_queue #(
		.WIDTH(QW),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din({f_cmd, f_col, f_rmask, f_cmask}),
		.full(q_full),
		.pop(q_pop),
		.dout(q_dout),
		.empty(q_empty)
	);

	assign {b_cmd, b_col, b_rmask, b_cmask} = q_dout;

	ssconv_back #(
		.MAX_KERNEL(MAX_KERNEL),
		.MAX_COLS(MAX_COLS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_cmd(b_cmd),
		.q_col(b_col),
		.q_rmask(b_rmask),
		.q_cmask(b_cmask),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

endmodule

>>> rtl/ssconv_queue.sv
module ssconv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] din,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0] cnt_q;

	assign full = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

>>> rtl/ssconv_front.sv
module ssconv_front #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_COLS = 1024
) (
	input logic clk,
	input logic arst_n,
	input ssconv_pkg::cfg_t cfg,
	input logic restart,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_op,
	input logic [5:0] in_coef_index,
	input logic signed [23:0] in_coef_value,
	input logic signed [31:0] in_sample,
	input logic q_full,
	output logic q_push,
	output ssconv_pkg::cmd_t q_cmd,
	output logic [$clog2(MAX_COLS)-1:0] q_col,
	output logic [MAX_KERNEL-1:0] q_rmask,
	output logic [MAX_KERNEL-1:0] q_cmask
);
	import ssconv_pkg::*;

	localparam int COLW = $clog2(MAX_COLS);
	localparam int CW = $clog2(MAX_COLS + 1);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int PW = $clog2((MAX_ROWS + MAX_KERNEL) * MAX_COLS + MAX_KERNEL + 1);

	logic [ROWS_W-1:0] rows_e;
	logic [CW-1:0] cols_e;
	logic [KW-1:0] k_e, half;
	logic [PW-1:0] total, lag, pos_q;
	logic [COLW-1:0] scol_q, ocol_q;
	logic [OROW_W-1:0] orow_q;
	logic accept, is_step, coef_ok, emit, last, col_end, ocol_end;

	always_comb begin
		rows_e = ROWS_W'(clamp_cfg(int'(cfg.rows), MAX_ROWS));
		cols_e = CW'(clamp_cfg(int'(cfg.cols), MAX_COLS));
		k_e = KW'(clamp_cfg(int'(cfg.ksize), MAX_KERNEL));
		half = k_e >> 1;
		total = PW'(rows_e) * PW'(cols_e);
		lag = PW'(half) * PW'(cols_e) + PW'(half);
	end

	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;
	assign is_step = (in_op == OP_SAMPLE) || (in_op == OP_FLUSH);
	assign coef_ok = (in_op == OP_COEF) && (int'(in_coef_index) < MAX_KERNEL * MAX_KERNEL);
	assign emit = pos_q >= lag;
	assign col_end = CW'(scol_q) == cols_e - CW'(1);
	assign ocol_end = CW'(ocol_q) == cols_e - CW'(1);
	assign last = emit && (ROWS_W'(orow_q) == rows_e - ROWS_W'(1)) && ocol_end;
	assign q_push = accept && (is_step || coef_ok);
	assign q_col = scol_q;

	always_comb begin
		q_cmd.is_coef = in_op == OP_COEF;
		q_cmd.coef_index = in_coef_index;
		q_cmd.coef_value = in_coef_value;
		// flush items and samples past the end of the matrix enter as zero
		q_cmd.data = ((in_op == OP_SAMPLE) && (pos_q < total)) ? in_sample : '0;
		q_cmd.emit = emit;
		q_cmd.row = orow_q;
		q_cmd.col = OCOL_W'(ocol_q);
		q_cmd.last = last;
	end

	// taps that fall inside the matrix for the element leaving now
	always_comb begin
		int r;
		int cc;
		for (int k = 0; k < MAX_KERNEL; k++) begin
			r = int'(orow_q) + k - int'(half);
			cc = int'(ocol_q) + k - int'(half);
			q_rmask[k] = (k < int'(k_e)) && (r >= 0) && (r < int'(rows_e));
			q_cmask[k] = (k < int'(k_e)) && (cc >= 0) && (cc < int'(cols_e));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			scol_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (restart) begin
			pos_q <= '0;
			scol_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
		end else if (accept && is_step) begin
			if (last) begin
				pos_q <= '0;
				scol_q <= '0;
				orow_q <= '0;
				ocol_q <= '0;
			end else begin
				pos_q <= pos_q + PW'(1);
				scol_q <= col_end ? '0 : scol_q + COLW'(1);
				if (emit) begin
					if (ocol_end) begin
						ocol_q <= '0;
						orow_q <= orow_q + OROW_W'(1);
					end else begin
						ocol_q <= ocol_q + COLW'(1);
					end
				end
			end
		end
	end

endmodule

>>> rtl/ssconv_back.sv
module ssconv_back #(
	parameter int MAX_KERNEL = 7,
	parameter int MAX_COLS = 1024
) (
	input logic clk,
	input logic arst_n,
	input ssconv_pkg::cfg_t cfg,
	input logic q_empty,
	output logic q_pop,
	input ssconv_pkg::cmd_t q_cmd,
	input logic [$clog2(MAX_COLS)-1:0] q_col,
	input logic [MAX_KERNEL-1:0] q_rmask,
	input logic [MAX_KERNEL-1:0] q_cmask,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [55:0] m_axis_tdata,
	output logic m_axis_tlast
);
	import ssconv_pkg::*;

	localparam int NT = MAX_KERNEL * MAX_KERNEL;
	localparam int NTW = (NT > 1) ? $clog2(NT) : 1;
	localparam int CMAX = MAX_KERNEL / 2;
	localparam int WIN = 2 * CMAX + 1;
	localparam int WIW = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int NLB = (WIN > 1) ? WIN - 1 : 1;
	localparam int COLW = $clog2(MAX_COLS);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int LEV = (NT > 1) ? $clog2(NT) : 1;
	localparam int OFD = 2 ** $clog2(LEV + 8);
	localparam int OAW = $clog2(OFD);
	localparam int SW = ACC_W - FRAC_W - OUT_W + 1;

	logic [KW-1:0] k_e;
	logic [OAW:0] credit_q;
	logic out_acc, wr_s1;

	// stage 1: line buffer read
	logic v_s1, fwd_s1;
	cmd_t cmd_s1;
	logic [COLW-1:0] col_s1;
	logic [MAX_KERNEL-1:0] rm_s1, cm_s1;
	logic signed [SAMPLE_W-1:0] rd_s1 [NLB];
	logic signed [SAMPLE_W-1:0] vfwd_s1 [NLB];
	logic signed [SAMPLE_W-1:0] vec [WIN];
	logic signed [SAMPLE_W-1:0] lb_mem [NLB][MAX_COLS];
	logic signed [SAMPLE_W-1:0] win_q [WIN][WIN];

	// stage 2: multiply
	logic v_s2;
	cmd_t cmd_s2;
	logic [MAX_KERNEL-1:0] rm_s2, cm_s2;
	logic signed [COEF_W-1:0] kern_q [NT];
	logic signed [PROD_W-1:0] prod [NT];

	// adder tree
	logic signed [ACC_W-1:0] tree_q [LEV+1][NT];
	logic tv_q [LEV+1];
	meta_t tmeta_q [LEV+1];
	logic signed [ACC_W-1:0] rnd;
	logic signed [ACC_W-FRAC_W-1:0] quo;
	logic signed [OUT_W-1:0] filt;

	// result queue
	res_t ofifo_q [OFD];
	logic [OAW-1:0] wptr_q, rptr_q;
	logic [OAW:0] ocnt_q;

	assign k_e = KW'(clamp_cfg(int'(cfg.ksize), MAX_KERNEL));

	// every emitting sample item in flight holds a slot in the result queue
	assign q_pop = !q_empty && (credit_q < (OAW+1)'(OFD));
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign wr_s1 = v_s1 && !cmd_s1.is_coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + (OAW+1)'(q_pop && !q_cmd.is_coef && q_cmd.emit)
				- (OAW+1)'(out_acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= q_pop;
			// same column written by the item ahead: its write is not yet visible
			fwd_s1 <= q_pop && wr_s1 && (q_col == col_s1);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= q_cmd;
		col_s1 <= q_col;
		rm_s1 <= q_rmask;
		cm_s1 <= q_cmask;
		cmd_s2 <= cmd_s1;
		rm_s2 <= rm_s1;
		cm_s2 <= cm_s1;
		for (int m = 0; m < NLB; m++) begin
			vfwd_s1[m] <= vec[m];
		end
	end

	for (genvar m = 0; m < NLB; m++) begin : g_lb
		always_ff @(posedge clk) begin
			if (wr_s1) begin
				lb_mem[m][col_s1] <= vec[m];
			end
			if (q_pop) begin
				rd_s1[m] <= lb_mem[m][q_col];
			end
		end
	end

	// column vector, newest row first
	always_comb begin
		vec[0] = cmd_s1.data;
		for (int d = 1; d < WIN; d++) begin
			vec[d] = fwd_s1 ? vfwd_s1[d-1] : rd_s1[d-1];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			for (int d = 0; d < WIN; d++) begin
				win_q[d][0] <= vec[d];
				for (int a = 1; a < WIN; a++) begin
					win_q[d][a] <= win_q[d][a-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				kern_q[t] <= '0;
			end
		end else if (v_s2 && cmd_s2.is_coef) begin
			kern_q[NTW'(cmd_s2.coef_index)] <= cmd_s2.coef_value;
		end
	end

	// coefficient (k,l) meets the window at row depth 2c-k and column age 2c-l
	always_comb begin
		int two_c;
		int d;
		int a;
		two_c = 2 * (int'(k_e) / 2);
		for (int k = 0; k < MAX_KERNEL; k++) begin
			for (int l = 0; l < MAX_KERNEL; l++) begin
				d = two_c - k;
				a = two_c - l;
				prod[k*MAX_KERNEL+l] = '0;
				if (rm_s2[k] && cm_s2[l] && (d >= 0) && (a >= 0)) begin
					prod[k*MAX_KERNEL+l] = win_q[WIW'(d)][WIW'(a)] * kern_q[k*MAX_KERNEL+l];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= LEV; s++) begin
				tv_q[s] <= 1'b0;
			end
		end else begin
			tv_q[0] <= v_s2 && !cmd_s2.is_coef && cmd_s2.emit;
			for (int s = 1; s <= LEV; s++) begin
				tv_q[s] <= tv_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tmeta_q[0] <= '{last: cmd_s2.last, col: cmd_s2.col, row: cmd_s2.row};
		for (int t = 0; t < NT; t++) begin
			tree_q[0][t] <= ACC_W'(prod[t]);
		end
		for (int s = 1; s <= LEV; s++) begin
			tmeta_q[s] <= tmeta_q[s-1];
			for (int e = 0; e < NT; e++) begin
				if (2 * e + 1 < NT) begin
					tree_q[s][e] <= tree_q[s-1][2*e] + tree_q[s-1][2*e+1];
				end else if (2 * e < NT) begin
					tree_q[s][e] <= tree_q[s-1][2*e];
				end else begin
					tree_q[s][e] <= '0;
				end
			end
		end
	end

	// round half up, back to q16.16, saturate
	always_comb begin
		rnd = tree_q[LEV][0] + ACC_W'(1 << (FRAC_W - 1));
		quo = rnd[ACC_W-1:FRAC_W];
		if ((quo[ACC_W-FRAC_W-1:OUT_W-1] == {SW{1'b0}})
			|| (quo[ACC_W-FRAC_W-1:OUT_W-1] == {SW{1'b1}})) begin
			filt = quo[OUT_W-1:0];
		end else if (quo[ACC_W-FRAC_W-1]) begin
			filt = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			filt = {1'b0, {(OUT_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (tv_q[LEV]) begin
			ofifo_q[wptr_q] <= '{meta: tmeta_q[LEV], filtered: filt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			ocnt_q <= '0;
		end else begin
			if (tv_q[LEV]) begin
				wptr_q <= wptr_q + OAW'(1);
			end
			if (out_acc) begin
				rptr_q <= rptr_q + OAW'(1);
			end
			ocnt_q <= ocnt_q + (OAW+1)'(tv_q[LEV]) - (OAW+1)'(out_acc);
		end
	end

	assign m_axis_tvalid = ocnt_q != '0;
	assign m_axis_tdata = {2'b00, ofifo_q[rptr_q].meta.col, ofifo_q[rptr_q].meta.row,
		ofifo_q[rptr_q].filtered};
	assign m_axis_tlast = ofifo_q[rptr_q].meta.last;

endmodule
